### rtl/core/timer_task_scheduler_defines.svh
// assertion macros for the timer task scheduler
// used by rtl/core modules that check their own logic
`ifndef TIMER_TASK_SCHEDULER_DEFINES_SVH
`define TIMER_TASK_SCHEDULER_DEFINES_SVH
`ifndef SYNTH
`define TTS_ASSERT_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("lbl");
`define TTS_ASSERT_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("lbl");
`else
`define TTS_ASSERT_IMP(lbl, clk, rst, a, c)
`define TTS_ASSERT_NEXT(lbl, clk, rst, a, c)
`endif
`endif

### rtl/core/tts_pkg.sv
// shared types and constants of the timer task scheduler
// no dependencies
`timescale 1ns / 1ps
package tts_pkg;
  localparam int NumSlots = 16;
  localparam int SlotBits = 4;
  localparam int TimeBits = 48;
  localparam int IvBits = 32;
  localparam int StampBits = 32;
  localparam logic [TimeBits-1:0] TMax = {TimeBits{1'b1}};

  localparam logic [2:0] OP_TICK = 3'd0;
  localparam logic [2:0] OP_SINGLE = 3'd1;
  localparam logic [2:0] OP_PERIODIC = 3'd2;
  localparam logic [2:0] OP_WATCHDOG = 3'd3;
  localparam logic [2:0] OP_KICK = 3'd4;
  localparam logic [2:0] OP_REMOVE = 3'd5;

  localparam logic [1:0] K_SINGLE = 2'd0;
  localparam logic [1:0] K_PERIODIC = 2'd1;
  localparam logic [1:0] K_WATCHDOG = 2'd2;
  localparam logic [1:0] K_FINISHED = 2'd3;

  localparam logic [1:0] R_ACK = 2'd0;
  localparam logic [1:0] R_FIRED = 2'd1;
  localparam logic [1:0] R_IDLE = 2'd2;

  localparam int EntryBits = TimeBits + IvBits + StampBits;

  typedef struct packed {
    logic [TimeBits-1:0] expiry;
    logic [IvBits-1:0] interval;
    logic [StampBits-1:0] stamp;
  } entry_t;

  function automatic logic [TimeBits-1:0] sat_add(input logic [TimeBits-1:0] a,
                                                  input logic [TimeBits-1:0] b);
    logic [TimeBits:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[TimeBits] ? TMax : s[TimeBits-1:0];
  endfunction
endpackage

### rtl/core/tts_ram.sv
// generic single-port-write, one-read ram with registered read
// no dependencies
`timescale 1ns / 1ps
module tts_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### rtl/core/timer_task_scheduler.sv
// timer task scheduler top level: slot table in ram, tick scan and fire
// depends on tts_pkg, tts_ram, timer_task_scheduler_defines.svh
//
// channel | direction | handshake      | words
// command | in        | start / busy   | opcode task_id start_time interval
// result  | out       | strobe         | kind slot_out status is_active now_ms last
//
// a command reads the ram at accept, then writes back and answers in S_CMD
// a tick rescans the slot ram for each fired slot and once more to finish: each scan
// reads the slot ram at one entry per cycle, then S_FIRE picks and S_FWR writes back
// rst is synchronous; kind and active flags reset, ram contents stay undefined
// results cannot be stalled; busy stays high until the last word goes out
`timescale 1ns / 1ps
`include "timer_task_scheduler_defines.svh"
module timer_task_scheduler (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  opcode,
  input  logic [3:0]  task_id,
  input  logic [47:0] start_time,
  input  logic [31:0] interval,
  output logic        strobe,
  output logic [1:0]  kind,
  output logic [3:0]  slot_out,
  output logic        status,
  output logic        is_active,
  output logic [47:0] now_ms,
  output logic        last
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CMD = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_FIRE = 3'd3;
  localparam logic [2:0] S_FWR = 3'd4;

  logic [2:0] state;
  logic [2:0] op;
  logic [tts_pkg::SlotBits-1:0] id;
  logic [tts_pkg::TimeBits-1:0] st;
  logic [tts_pkg::IvBits-1:0] iv;
  logic [tts_pkg::TimeBits-1:0] now_count;
  logic [tts_pkg::StampBits-1:0] stamp_counter;
  logic [1:0] slot_kind [tts_pkg::NumSlots];
  logic [tts_pkg::NumSlots-1:0] slot_active;
  logic [tts_pkg::NumSlots-1:0] fired;
  logic [tts_pkg::SlotBits:0] scan_cnt;
  logic [tts_pkg::SlotBits:0] due_cnt;
  logic rd_valid;
  logic [tts_pkg::SlotBits-1:0] rd_idx;
  logic have_best;
  logic [tts_pkg::SlotBits-1:0] best;
  tts_pkg::entry_t best_e;
  logic any_fired;

  logic we;
  logic [tts_pkg::SlotBits-1:0] waddr, raddr;
  tts_pkg::entry_t wdata, rdata;

  tts_ram #(.Width(tts_pkg::EntryBits), .Depth(tts_pkg::NumSlots)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign busy = (state != S_IDLE);

  logic cand;
  logic better;
  assign cand = rd_valid && slot_active[rd_idx] && !fired[rd_idx]
                && (rdata.expiry <= now_count);
  assign better = !have_best || (rdata.expiry < best_e.expiry) ||
                  ((rdata.expiry == best_e.expiry) && (rdata.stamp < best_e.stamp));

  logic [tts_pkg::IvBits-1:0] iv1;
  assign iv1 = (interval == '0) ? tts_pkg::IvBits'(1) : interval;

  always_comb begin
    raddr = (state == S_IDLE) ? task_id : scan_cnt[tts_pkg::SlotBits-1:0];
    we = 1'b0;
    waddr = id;
    wdata = rdata;
    if (state == S_CMD) begin
      waddr = id;
      wdata.stamp = stamp_counter;
      case (op)
        tts_pkg::OP_SINGLE: begin
          we = 1'b1;
          wdata.expiry = st;
          wdata.interval = '0;
        end
        tts_pkg::OP_PERIODIC: begin
          we = 1'b1;
          wdata.expiry = st;
          wdata.interval = iv;
        end
        tts_pkg::OP_WATCHDOG: begin
          we = 1'b1;
          wdata.interval = iv;
          wdata.expiry = tts_pkg::sat_add(now_count, {16'd0, iv});
        end
        tts_pkg::OP_KICK: begin
          we = slot_active[id];
          wdata.expiry = tts_pkg::sat_add(now_count, {16'd0, rdata.interval});
        end
        default: we = 1'b0;
      endcase
    end else if (state == S_FWR) begin
      waddr = best;
      wdata.expiry = tts_pkg::sat_add(best_e.expiry, {16'd0, best_e.interval});
      wdata.interval = best_e.interval;
      wdata.stamp = stamp_counter;
      we = (slot_kind[best] == tts_pkg::K_PERIODIC);
    end
  end

  always_ff @(posedge clk) begin
    strobe <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      now_count <= '0;
      stamp_counter <= '0;
      slot_active <= '0;
      for (int i = 0; i < tts_pkg::NumSlots; i++) slot_kind[i] <= tts_pkg::K_FINISHED;
      rd_valid <= 1'b0;
      have_best <= 1'b0;
      fired <= '0;
      scan_cnt <= '0;
      due_cnt <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            op <= opcode;
            id <= task_id;
            st <= start_time;
            iv <= iv1;
            if (opcode == tts_pkg::OP_TICK) begin
              now_count <= tts_pkg::sat_add(now_count, tts_pkg::TimeBits'(1));
              fired <= '0;
              any_fired <= 1'b0;
              scan_cnt <= '0;
              due_cnt <= '0;
              rd_valid <= 1'b0;
              have_best <= 1'b0;
              state <= S_SCAN;
            end else begin
              state <= S_CMD;
            end
          end
        end
        S_CMD: begin
          strobe <= 1'b1;
          kind <= tts_pkg::R_ACK;
          slot_out <= id;
          last <= 1'b1;
          now_ms <= now_count;
          status <= 1'b0;
          is_active <= slot_active[id];
          case (op)
            tts_pkg::OP_SINGLE, tts_pkg::OP_PERIODIC, tts_pkg::OP_WATCHDOG: begin
              slot_kind[id] <= (op == tts_pkg::OP_SINGLE) ? tts_pkg::K_SINGLE :
                               (op == tts_pkg::OP_PERIODIC) ? tts_pkg::K_PERIODIC :
                               tts_pkg::K_WATCHDOG;
              slot_active[id] <= 1'b1;
              stamp_counter <= stamp_counter + 1'b1;
              is_active <= 1'b1;
            end
            tts_pkg::OP_KICK: begin
              if (!slot_active[id]) status <= 1'b1;
              else begin
                if (slot_kind[id] == tts_pkg::K_PERIODIC) slot_kind[id] <= tts_pkg::K_SINGLE;
                stamp_counter <= stamp_counter + 1'b1;
              end
            end
            tts_pkg::OP_REMOVE: begin
              if (!slot_active[id]) status <= 1'b1;
              else begin
                slot_active[id] <= 1'b0;
                slot_kind[id] <= tts_pkg::K_FINISHED;
                is_active <= 1'b0;
              end
            end
            default: ;
          endcase
          state <= S_IDLE;
        end
        S_SCAN: begin
          rd_valid <= !scan_cnt[tts_pkg::SlotBits];
          rd_idx <= scan_cnt[tts_pkg::SlotBits-1:0];
          if (!scan_cnt[tts_pkg::SlotBits]) scan_cnt <= scan_cnt + 1'b1;
          if (cand) due_cnt <= due_cnt + 1'b1;
          if (cand && better) begin
            have_best <= 1'b1;
            best <= rd_idx;
            best_e <= rdata;
          end
          if (scan_cnt[tts_pkg::SlotBits] && !rd_valid) state <= S_FIRE;
        end
        S_FIRE: begin
          if (!have_best) begin
            if (!any_fired) begin
              strobe <= 1'b1;
              kind <= tts_pkg::R_IDLE;
              slot_out <= '0;
              status <= 1'b0;
              is_active <= 1'b0;
              now_ms <= now_count;
              last <= 1'b1;
            end
            state <= S_IDLE;
          end else begin
            state <= S_FWR;
          end
        end
        default: begin
          fired[best] <= 1'b1;
          any_fired <= 1'b1;
          if (slot_kind[best] == tts_pkg::K_PERIODIC) begin
            stamp_counter <= stamp_counter + 1'b1;
          end else begin
            slot_active[best] <= 1'b0;
            slot_kind[best] <= tts_pkg::K_FINISHED;
          end
          strobe <= 1'b1;
          kind <= tts_pkg::R_FIRED;
          slot_out <= best;
          status <= 1'b0;
          is_active <= (slot_kind[best] == tts_pkg::K_PERIODIC);
          now_ms <= now_count;
          // last when this slot was the only due one left in the scan
          last <= (due_cnt == (tts_pkg::SlotBits+1)'(1));
          have_best <= 1'b0;
          scan_cnt <= '0;
          due_cnt <= '0;
          rd_valid <= 1'b0;
          state <= S_SCAN;
        end
      endcase
    end
  end

  `TTS_ASSERT_IMP(a_strobe_busy, clk, rst, strobe && !last, busy)
  `TTS_ASSERT_NEXT(a_cmd_one, clk, rst, state == S_CMD, strobe && last && state == S_IDLE)
  `TTS_ASSERT_IMP(a_fire_valid, clk, rst, state == S_FWR, have_best)
endmodule
